// ===== sv/lca_pkg.sv =====
// Shared constants, types and table access structs for the lowest common ancestor block.
`default_nettype none

package lca_pkg;

    localparam int NODES     = 1024;
    localparam int LEVELS    = 10;
    localparam int ID_W      = 10;
    localparam int DEPTH_W   = 10;
    localparam int DIST_W    = 11;
    localparam int NODE_W    = $clog2(NODES);
    localparam int LVL_IDX_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int LVL_CNT_W = $clog2(LEVELS + 1);
    localparam int ANC_ENTRIES = NODES * LEVELS;
    localparam int ANC_AW    = $clog2(ANC_ENTRIES);

    typedef logic [NODE_W-1:0]    node_t;
    typedef logic [DEPTH_W-1:0]   depth_t;
    typedef logic [LVL_IDX_W-1:0] lvl_t;

    localparam depth_t DEPTH_MAX = '1;

    typedef enum logic
    {
        CMD_ADD   = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef struct packed
    {
        logic  en;
        node_t node;
    } depth_rd_t;

    typedef struct packed
    {
        logic   en;
        node_t  node;
        depth_t data;
    } depth_wr_t;

    typedef struct packed
    {
        logic  en;
        node_t node;
        lvl_t  lvl;
    } anc_rd_t;

    typedef struct packed
    {
        logic  en;
        node_t node;
        lvl_t  lvl;
        node_t data;
    } anc_wr_t;

endpackage

`default_nettype wire

// ===== sv/lca_if.sv =====
// Valid/ready channel interfaces for request and result items.
`default_nettype none

interface lca_req_if;
    import lca_pkg::*;

    logic            valid;
    logic            ready;
    logic            command;
    logic [ID_W-1:0] node_id;
    logic [ID_W-1:0] other_id;

    modport source (output valid, command, node_id, other_id, input ready);
    modport sink   (input valid, command, node_id, other_id, output ready);
endinterface

interface lca_res_if;
    import lca_pkg::*;

    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   common_ancestor;
    logic [DIST_W-1:0] path_distance;

    modport source (output valid, common_ancestor, path_distance, input ready);
    modport sink   (input valid, common_ancestor, path_distance, output ready);
endinterface

`default_nettype wire

// ===== sv/lca_tables.sv =====
// Depth and ancestor memories with registered reads, write forwarding and sentinel masking.
`default_nettype none

module lca_tables
(
    input  wire logic              clk,
    input  wire lca_pkg::depth_rd_t dep_rd0,
    input  wire lca_pkg::depth_rd_t dep_rd1,
    input  wire lca_pkg::depth_wr_t dep_wr,
    input  wire lca_pkg::anc_rd_t   anc_rd_a,
    input  wire lca_pkg::anc_rd_t   anc_rd_b,
    input  wire lca_pkg::anc_wr_t   anc_wr,
    output lca_pkg::depth_t         dep_q0,
    output lca_pkg::depth_t         dep_q1,
    output lca_pkg::node_t          anc_qa,
    output lca_pkg::node_t          anc_qb
);
    import lca_pkg::*;

    depth_t depth_mem [NODES];
    node_t  anc_mem   [ANC_ENTRIES];

    depth_t dep_raw0_reg;
    depth_t dep_raw1_reg;
    logic   dep_zero0_reg;
    logic   dep_zero1_reg;
    node_t  anc_raw_a_reg;
    node_t  anc_raw_b_reg;
    logic   anc_zero_a_reg;
    logic   anc_zero_b_reg;
    logic   fwd_a_reg;
    logic   fwd_b_reg;
    node_t  fwd_data_a_reg;
    node_t  fwd_data_b_reg;

    function automatic logic [ANC_AW-1:0] anc_addr(input node_t n, input lvl_t l);
        return ANC_AW'(n) * ANC_AW'(LEVELS) + ANC_AW'(l);
    endfunction

    always_ff @(posedge clk)
    begin
        if (dep_wr.en)
        begin
            depth_mem[dep_wr.node] <= dep_wr.data;
        end
        if (anc_wr.en)
        begin
            anc_mem[anc_addr(anc_wr.node, anc_wr.lvl)] <= anc_wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dep_rd0.en)
        begin
            dep_raw0_reg  <= depth_mem[dep_rd0.node];
            dep_zero0_reg <= (dep_rd0.node == '0);
        end
        if (dep_rd1.en)
        begin
            dep_raw1_reg  <= depth_mem[dep_rd1.node];
            dep_zero1_reg <= (dep_rd1.node == '0);
        end
    end

    // Take the value being written when a read hits the same entry in the same cycle
    always_ff @(posedge clk)
    begin
        if (anc_rd_a.en)
        begin
            anc_raw_a_reg  <= anc_mem[anc_addr(anc_rd_a.node, anc_rd_a.lvl)];
            anc_zero_a_reg <= (anc_rd_a.node == '0);
            fwd_a_reg      <= anc_wr.en && (anc_wr.node == anc_rd_a.node)
                              && (anc_wr.lvl == anc_rd_a.lvl);
            fwd_data_a_reg <= anc_wr.data;
        end
        if (anc_rd_b.en)
        begin
            anc_raw_b_reg  <= anc_mem[anc_addr(anc_rd_b.node, anc_rd_b.lvl)];
            anc_zero_b_reg <= (anc_rd_b.node == '0);
            fwd_b_reg      <= anc_wr.en && (anc_wr.node == anc_rd_b.node)
                              && (anc_wr.lvl == anc_rd_b.lvl);
            fwd_data_b_reg <= anc_wr.data;
        end
    end

    // Node zero is the sentinel: it is never written and always reads as zero
    assign dep_q0 = dep_zero0_reg ? '0 : dep_raw0_reg;
    assign dep_q1 = dep_zero1_reg ? '0 : dep_raw1_reg;
    assign anc_qa = anc_zero_a_reg ? '0 : (fwd_a_reg ? fwd_data_a_reg : anc_raw_a_reg);
    assign anc_qb = anc_zero_b_reg ? '0 : (fwd_b_reg ? fwd_data_b_reg : anc_raw_b_reg);

endmodule

`default_nettype wire

// ===== sv/lca_binary_lifting.sv =====
// A query walks the ancestor memory with dependent reads: one level per cycle
// while lifting and while descending, and the descent is skipped when the lift lands on
// the other node. The next item can be accepted in the cycle after the result is loaded,
// while the result waits in the output register; a query whose result finds it full stalls.
// Reset clears control state only; tables hold garbage until written, node zero reads zero.
`default_nettype none

module lca_binary_lifting
(
    input wire logic clk,
    input wire logic rst_n,
    lca_req_if.sink   request,
    lca_res_if.source result
);
    import lca_pkg::*;

    typedef enum logic [10:0]
    {
        S_IDLE    = 11'b000_0000_0001,
        S_ADD0    = 11'b000_0000_0010,
        S_ADD_LVL = 11'b000_0000_0100,
        S_Q_DEP   = 11'b000_0000_1000,
        S_Q_ORDER = 11'b000_0001_0000,
        S_LIFT    = 11'b000_0010_0000,
        S_DESC0   = 11'b000_0100_0000,
        S_DESC    = 11'b000_1000_0000,
        S_FINAL   = 11'b001_0000_0000,
        S_Q_DW    = 11'b010_0000_0000,
        S_Q_OUT   = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // x/y hold the added node and its parent during an add, the two walkers in a query
    node_t                 x_reg, x_next;
    node_t                 y_reg, y_next;
    node_t                 w_reg, w_next;
    logic [LVL_CNT_W-1:0]  j_reg, j_next;
    logic                  pend_reg, pend_next;
    logic [LEVELS-1:0]     mask_reg, mask_next;
    logic [DIST_W-1:0]     sum_reg, sum_next;
    logic [ID_W-1:0]       out_anc_reg, out_anc_next;
    logic [DIST_W-1:0]     out_dist_reg, out_dist_next;

    depth_rd_t dep_rd0, dep_rd1;
    depth_wr_t dep_wr;
    anc_rd_t   anc_rd_a, anc_rd_b;
    anc_wr_t   anc_wr;
    depth_t    dep_q0, dep_q1;
    node_t     anc_qa, anc_qb;

    node_t             x_eff;
    node_t             x_desc;
    node_t             y_desc;
    depth_t            dep_inc;
    depth_t            diff;
    logic [DIST_W-1:0] two_dw;
    node_t             req_node;
    node_t             req_other;

    lca_tables u_tables
    (
        .clk      (clk),
        .dep_rd0  (dep_rd0),
        .dep_rd1  (dep_rd1),
        .dep_wr   (dep_wr),
        .anc_rd_a (anc_rd_a),
        .anc_rd_b (anc_rd_b),
        .anc_wr   (anc_wr),
        .dep_q0   (dep_q0),
        .dep_q1   (dep_q1),
        .anc_qa   (anc_qa),
        .anc_qb   (anc_qb)
    );

    assign request.ready          = (state_reg == S_IDLE);
    assign result.valid           = out_valid_reg;
    assign result.common_ancestor = out_anc_reg;
    assign result.path_distance   = out_dist_reg;

    assign req_node  = NODE_W'(request.node_id);
    assign req_other = NODE_W'(request.other_id);

    // A lift read issued last cycle lands in the memory output; otherwise keep the walker
    assign x_eff = pend_reg ? anc_qa : x_reg;

    // Descend: step both walkers only where their ancestors differ
    assign x_desc = (anc_qa != anc_qb) ? anc_qa : x_reg;
    assign y_desc = (anc_qa != anc_qb) ? anc_qb : y_reg;

    // Saturate the child depth at the top of the depth range
    assign dep_inc = (dep_q0 == DEPTH_MAX) ? DEPTH_MAX : dep_q0 + 1'b1;
    assign diff    = (dep_q0 < dep_q1) ? dep_q1 - dep_q0 : dep_q0 - dep_q1;
    assign two_dw  = {dep_q0, 1'b0};

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !result.ready;
        x_next         = x_reg;
        y_next         = y_reg;
        w_next         = w_reg;
        j_next         = j_reg;
        pend_next      = pend_reg;
        mask_next      = mask_reg;
        sum_next       = sum_reg;
        out_anc_next   = out_anc_reg;
        out_dist_next  = out_dist_reg;
        dep_rd0        = '0;
        dep_rd1        = '0;
        dep_wr         = '0;
        anc_rd_a       = '0;
        anc_rd_b       = '0;
        anc_wr         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (request.valid)
                begin
                    x_next = req_node;
                    y_next = req_other;
                    if (cmd_t'(request.command) == CMD_QUERY)
                    begin
                        state_next = S_Q_DEP;
                    end
                    else if (req_node != '0)
                    begin
                        // Drop an add of the sentinel
                        state_next = S_ADD0;
                    end
                end
            end

            S_ADD0:
            begin
                // Level zero is the parent itself; fetch the parent's depth and level zero
                anc_wr     = '{en: 1'b1, node: x_reg, lvl: '0, data: y_reg};
                dep_rd0    = '{en: 1'b1, node: y_reg};
                anc_rd_a   = '{en: 1'b1, node: y_reg, lvl: '0};
                j_next     = LVL_CNT_W'(1);
                state_next = S_ADD_LVL;
            end

            S_ADD_LVL:
            begin
                if (j_reg < LVL_CNT_W'(LEVELS))
                begin
                    anc_wr = '{en: 1'b1, node: x_reg, lvl: LVL_IDX_W'(j_reg), data: anc_qa};
                end
                if (j_reg == LVL_CNT_W'(1))
                begin
                    dep_wr = '{en: 1'b1, node: x_reg,
                               data: (y_reg == '0) ? depth_t'(0) : dep_inc};
                end
                if (j_reg < LVL_CNT_W'(LEVELS - 1))
                begin
                    anc_rd_a = '{en: 1'b1, node: anc_qa, lvl: LVL_IDX_W'(j_reg)};
                    j_next   = j_reg + 1'b1;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_Q_DEP:
            begin
                dep_rd0    = '{en: 1'b1, node: x_reg};
                dep_rd1    = '{en: 1'b1, node: y_reg};
                state_next = S_Q_ORDER;
            end

            S_Q_ORDER:
            begin
                // Put the deeper node in x
                if (dep_q0 < dep_q1)
                begin
                    x_next = y_reg;
                    y_next = x_reg;
                end
                mask_next  = LEVELS'(diff);
                sum_next   = DIST_W'(dep_q0) + DIST_W'(dep_q1);
                pend_next  = 1'b0;
                j_next     = '0;
                state_next = S_LIFT;
            end

            S_LIFT:
            begin
                x_next = x_eff;
                if (mask_reg[0])
                begin
                    anc_rd_a = '{en: 1'b1, node: x_eff, lvl: LVL_IDX_W'(j_reg)};
                end
                pend_next = mask_reg[0];
                mask_next = mask_reg >> 1;
                j_next    = j_reg + 1'b1;
                if (j_reg == LVL_CNT_W'(LEVELS - 1))
                begin
                    state_next = S_DESC0;
                end
            end

            S_DESC0:
            begin
                if (x_eff == y_reg)
                begin
                    w_next     = x_eff;
                    state_next = S_Q_DW;
                end
                else
                begin
                    x_next     = x_eff;
                    anc_rd_a   = '{en: 1'b1, node: x_eff, lvl: LVL_IDX_W'(LEVELS - 1)};
                    anc_rd_b   = '{en: 1'b1, node: y_reg, lvl: LVL_IDX_W'(LEVELS - 1)};
                    j_next     = LVL_CNT_W'(LEVELS - 1);
                    state_next = S_DESC;
                end
            end

            S_DESC:
            begin
                x_next = x_desc;
                y_next = y_desc;
                if (j_reg != '0)
                begin
                    anc_rd_a = '{en: 1'b1, node: x_desc, lvl: LVL_IDX_W'(j_reg - 1'b1)};
                    anc_rd_b = '{en: 1'b1, node: y_desc, lvl: LVL_IDX_W'(j_reg - 1'b1)};
                    j_next   = j_reg - 1'b1;
                end
                else
                begin
                    // The answer is the parent of the last differing walker
                    anc_rd_a   = '{en: 1'b1, node: x_desc, lvl: '0};
                    state_next = S_FINAL;
                end
            end

            S_FINAL:
            begin
                w_next     = anc_qa;
                state_next = S_Q_DW;
            end

            S_Q_DW:
            begin
                dep_rd0    = '{en: 1'b1, node: w_reg};
                state_next = S_Q_OUT;
            end

            S_Q_OUT:
            begin
                // Hold the depth read until the output register is free
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_anc_next   = ID_W'(w_reg);
                    out_dist_next  = (sum_reg < two_dw) ? '0 : sum_reg - two_dw;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        w_reg        <= w_next;
        j_reg        <= j_next;
        pend_reg     <= pend_next;
        mask_reg     <= mask_next;
        sum_reg      <= sum_next;
        out_anc_reg  <= out_anc_next;
        out_dist_reg <= out_dist_next;
    end

    // The sentinel entries must never be overwritten
    a_no_sentinel_write: assert property (@(posedge clk) disable iff (!rst_n)
        anc_wr.en |-> (anc_wr.node != '0))
        else $error("ancestor write to sentinel node");

    // A result only appears out of the output state of a query
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_Q_OUT))
        else $error("result raised outside query output state");

    // Lifting runs its level count and then moves on to the descent
    a_lift_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LIFT) |=> (state_reg == S_LIFT || state_reg == S_DESC0))
        else $error("lift phase left to wrong state");

    // No request is taken while an add or query is in progress
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !request.ready)
        else $error("request ready while busy");

endmodule

`default_nettype wire

// ===== dv/tb_lca_binary_lifting.sv =====
// Testbench for lca_binary_lifting: random and directed add/query items checked against a predictor.
`timescale 1ns / 100ps

module tb_lca_binary_lifting;

    import lca_pkg::*;

    // One request item as the driver sends it.
    typedef struct
    {
        cmd_t  command;
        node_t node_id;
        node_t other_id;
    } lca_item_t;

    // What a query is expected to return.
    typedef struct
    {
        node_t             ancestor;
        logic [DIST_W-1:0] distance;
    } lca_answer_t;

    localparam int DRAIN_CYCLES = 3 * LEVELS + 10;
    localparam int PRINT_CAP    = 200;
    localparam int CHAIN_TOP    = 320;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Driven copies of the block's inputs; the initializers give known values from time zero.
    logic  req_valid   = 1'b0;
    cmd_t  req_command = CMD_ADD;
    node_t req_node    = '0;
    node_t req_other   = '0;
    logic  res_ready   = 1'b0;

    lca_req_if request_ch ();
    lca_res_if result_ch ();

    assign request_ch.valid    = req_valid;
    assign request_ch.command  = req_command;
    assign request_ch.node_id  = req_node;
    assign request_ch.other_id = req_other;
    assign result_ch.ready     = res_ready;

    lca_binary_lifting u_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_ch),
        .result  (result_ch)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor: a private copy of the depth and ancestor tables.
    // Node zero is the sentinel and stays all zero.
    // ------------------------------------------------------------------
    depth_t depth_of [NODES];
    node_t  up_of    [NODES][LEVELS];

    lca_answer_t lca_answers [$];    // answers owed by the block, oldest first
    lca_item_t   pending_items [$];  // items not yet offered to the block

    // Stimulus bookkeeping: which nodes have been added, so no query or parent
    // ever names a node whose table entries were never written.
    bit    is_added [NODES];
    node_t added_nodes [$];
    node_t last_added;

    int mismatches       = 0;
    int adds_accepted    = 0;
    int queries_accepted = 0;
    int results_checked  = 0;
    int deepest          = 0;

    // Pause counters for both sides; a quiet count forces a run of back-to-back items.
    int req_pause = 0;
    int req_quiet = 0;
    int res_pause = 0;
    int res_quiet = 0;

    initial
    begin
        for (int n = 0; n < NODES; n++)
        begin
            depth_of[n] = '0;
            for (int j = 0; j < LEVELS; j++)
                up_of[n][j] = '0;
        end
    end

    // Store a node: depth from the parent (saturating), level 0 is the parent, every
    // higher level jumps twice along the level below. A root clears all levels.
    function automatic void record_add(node_t v, node_t p);
        if (v == '0)
            return;
        if (p == '0)
        begin
            depth_of[v] = '0;
            for (int j = 0; j < LEVELS; j++)
                up_of[v][j] = '0;
            return;
        end
        depth_of[v] = (depth_of[p] == DEPTH_MAX) ? DEPTH_MAX : depth_of[p] + 1'b1;
        if (int'(depth_of[v]) > deepest)
            deepest = int'(depth_of[v]);
        up_of[v][0] = p;
        for (int j = 1; j < LEVELS; j++)
            up_of[v][j] = up_of[up_of[v][j-1]][j-1];
    endfunction

    // Lift the deeper node by the depth difference, then descend from the top level
    // while the two ancestors differ.
    function automatic node_t common_of(node_t a, node_t b);
        node_t t;
        int    diff;
        if (depth_of[a] < depth_of[b])
        begin
            t = a;
            a = b;
            b = t;
        end
        diff = int'(depth_of[a]) - int'(depth_of[b]);
        for (int j = 0; j < LEVELS; j++)
            if (((diff >> j) & 1) != 0)
                a = up_of[a][j];
        if (a == b)
            return a;
        for (int j = LEVELS - 1; j >= 0; j--)
        begin
            if (up_of[a][j] != up_of[b][j])
            begin
                a = up_of[a][j];
                b = up_of[b][j];
            end
        end
        return up_of[a][0];
    endfunction

    // Apply one accepted item to the tables, or queue the answer a query owes.
    function automatic void apply_request(cmd_t cmd, node_t a, node_t b);
        lca_answer_t ans;
        int          span;
        if (cmd == CMD_ADD)
        begin
            adds_accepted++;
            record_add(a, b);
            return;
        end
        queries_accepted++;
        ans.ancestor = common_of(a, b);
        span = int'(depth_of[a]) + int'(depth_of[b]) - 2 * int'(depth_of[ans.ancestor]);
        // Clamp: tables made inconsistent by re-adds can push the distance out of range.
        if (span < 0)
            span = 0;
        if (span > 2047)
            span = 2047;
        ans.distance = span[DIST_W-1:0];
        lca_answers.insert(lca_answers.size(), ans);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("%0t ERROR: %s", $time, msg);
    endtask

    // Mostly short pauses, sometimes longer ones, rarely a long one.
    function automatic int draw_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_add(input node_t v, input node_t p);
        lca_item_t it;
        it.command  = CMD_ADD;
        it.node_id  = v;
        it.other_id = p;
        pending_items.insert(pending_items.size(), it);
        if (v != '0)
        begin
            if (!is_added[v])
            begin
                is_added[v] = 1'b1;
                added_nodes.insert(added_nodes.size(), v);
            end
            last_added = v;
        end
    endtask

    task automatic push_query(input node_t a, input node_t b);
        lca_item_t it;
        it.command  = CMD_QUERY;
        it.node_id  = a;
        it.other_id = b;
        pending_items.insert(pending_items.size(), it);
    endtask

    function automatic node_t pick_added();
        return added_nodes[$urandom_range(0, added_nodes.size() - 1)];
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer pending items, predict on each accepted one, pause at random.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        lca_item_t next_item;
        if (!rst_n)
        begin
            req_valid   <= 1'b0;
            req_command <= CMD_ADD;
            req_node    <= '0;
            req_other   <= '0;
        end
        else
        begin
            if (req_valid && request_ch.ready)
                apply_request(req_command, req_node, req_other);
            if (!req_valid || request_ch.ready)
            begin
                if (req_pause > 0)
                begin
                    req_pause--;
                    req_valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    next_item = pending_items.pop_front();
                    req_command <= next_item.command;
                    req_node    <= next_item.node_id;
                    req_other   <= next_item.other_id;
                    req_valid   <= 1'b1;
                    // Pick the pause that follows this item.
                    if (req_quiet > 0)
                    begin
                        req_quiet--;
                        req_pause = 0;
                    end
                    else
                    begin
                        req_pause = draw_pause();
                        if ($urandom_range(0, 63) == 0)
                            req_quiet = $urandom_range(16, 96);
                    end
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: take results with random back-pressure, compare with the oldest answer.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : check_results
        lca_answer_t want;
        if (!rst_n)
        begin
            res_ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && res_ready)
            begin
                results_checked++;
                if (lca_answers.size() == 0)
                begin
                    report_mismatch($sformatf("result with nothing owed: ancestor %0d distance %0d",
                                              result_ch.common_ancestor,
                                              result_ch.path_distance));
                end
                else
                begin
                    want = lca_answers.pop_front();
                    if (result_ch.common_ancestor !== want.ancestor)
                        report_mismatch($sformatf("common_ancestor %0d, want %0d",
                                                  result_ch.common_ancestor, want.ancestor));
                    if (result_ch.path_distance !== want.distance)
                        report_mismatch($sformatf("path_distance %0d, want %0d",
                                                  result_ch.path_distance, want.distance));
                end
                if (res_quiet > 0)
                begin
                    res_quiet--;
                    res_pause = 0;
                end
                else
                begin
                    res_pause = draw_pause();
                    if ($urandom_range(0, 31) == 0)
                        res_quiet = $urandom_range(8, 40);
                end
            end
            else if (res_pause == 0 && res_quiet == 0 && $urandom_range(0, 31) == 0)
            begin
                // Stall now and then even with no result waiting.
                res_pause = draw_pause();
            end

            if (res_pause > 0)
            begin
                res_pause--;
                res_ready <= 1'b0;
            end
            else
            begin
                res_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin : run_test
        int    rnd;
        node_t v;
        node_t p;
        node_t a;
        node_t b;

        last_added = '0;

        // Directed part: a small tree at the id extremes, sentinel queries, add of node
        // zero, re-adds that leave descendants with stale entries.
        push_add(10'd1023, 10'd0);       // root at the top id
        push_add(10'd1, 10'd1023);
        push_add(10'd2, 10'd1);
        push_add(10'd512, 10'd1023);
        push_add(10'd3, 10'd2);
        push_query(10'd3, 10'd512);      // lca is the root across branches
        push_query(10'd512, 10'd3);      // same pair, swapped
        push_query(10'd1023, 10'd1023);  // same node twice
        push_query(10'd3, 10'd1);        // one node is an ancestor of the other
        push_query(10'd0, 10'd3);        // sentinel on either side
        push_query(10'd3, 10'd0);
        push_query(10'd0, 10'd0);
        push_add(10'd0, 10'd1023);       // dropped: the sentinel keeps its zeros
        push_query(10'd0, 10'd1);
        push_add(10'd1, 10'd0);          // re-add as a root; node 2 and 3 keep old entries
        push_query(10'd3, 10'd1);
        push_query(10'd3, 10'd512);
        push_add(10'd2, 10'd512);        // move node 2 under another branch
        push_query(10'd3, 10'd2);
        push_add(10'd1022, 10'd3);
        push_query(10'd1022, 10'd1023);

        // Random part: mostly tree building and queries on added nodes. Parents lean
        // toward the last added node so the trees grow deep, with re-adds along the way.
        for (int i = 0; i < 560; i++)
        begin
            rnd = $urandom_range(0, 99);
            if (rnd < 48 || added_nodes.size() < 2)
            begin
                v = ($urandom_range(0, 49) == 0) ? 10'd0 : node_t'($urandom_range(1, NODES - 1));
                rnd = $urandom_range(0, 99);
                if (rnd < 10)
                    p = '0;
                else if (rnd < 60)
                    p = last_added;
                else
                    p = pick_added();
                push_add(v, p);
            end
            else
            begin
                a = pick_added();
                b = pick_added();
                if ($urandom_range(0, 29) == 0)
                    a = '0;
                if ($urandom_range(0, 29) == 0)
                    b = '0;
                push_query(a, b);
            end
        end

        // Deep chain: a long line of nodes for lifts across many levels, then close a
        // loop so node 1 sits below the end of the chain.
        push_add(10'd1, 10'd0);
        for (int k = 2; k <= CHAIN_TOP; k++)
        begin
            push_add(node_t'(k), node_t'(k - 1));
            if (k % 64 == 0)
                push_query(node_t'(k), pick_added());
        end
        push_query(node_t'(CHAIN_TOP), 10'd1);     // long lift
        push_query(node_t'(CHAIN_TOP), 10'd160);
        push_query(10'd0, node_t'(CHAIN_TOP));
        push_add(10'd1, node_t'(CHAIN_TOP));       // node 1 now hangs below the chain end
        push_add(10'd2, 10'd1);
        push_add(10'd3, 10'd2);
        push_query(10'd3, node_t'(CHAIN_TOP));
        push_query(10'd2, 10'd1);
        push_query(10'd300, 10'd2);
        for (int i = 0; i < 30; i++)
            push_query(pick_added(), pick_added());

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Hold until every item is in and every answer has come back, then let the
        // block run out its latency before the final check.
        while (pending_items.size() != 0 || req_valid || lca_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d adds and %0d queries, %0d results checked, deepest node %0d",
                 adds_accepted, queries_accepted, results_checked, deepest);
        $display("%0d mismatches, %0d answers left over", mismatches, lca_answers.size());
        if (mismatches == 0 && lca_answers.size() == 0)
            $display("tb_lca_binary_lifting: PASS");
        else
            $display("tb_lca_binary_lifting: FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #30_000_000;
        $display("timeout with %0d items pending and %0d answers owed",
                 pending_items.size(), lca_answers.size());
        $display("tb_lca_binary_lifting: FAIL");
        $finish;
    end

endmodule
